// ===== hdl/vln_pkg.sv =====
// vln_pkg: shared constants and the result word type for vector_length_and_normalize.
// No dependencies.
`timescale 1ns / 1ps

package vln_pkg;

    localparam int CompW    = 32;
    localparam int SqW      = 64;
    localparam int SqrtSteps = 32;
    localparam int QuotW    = 31;
    localparam int DivSteps = 31;
    localparam int Lanes    = 3;

    typedef struct packed {
        logic [CompW-1:0]        vec_length;
        logic signed [CompW-1:0] unit_x;
        logic signed [CompW-1:0] unit_y;
        logic signed [CompW-1:0] unit_z;
        logic                    zero_length;
    } res_t;

endpackage

// ===== hdl/vln_square_lane.sv =====
// vln_square_lane: magnitude and square of one signed component, two register stages.
// Depends on vln_pkg.
`timescale 1ns / 1ps

module vln_square_lane
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vln_pkg::CompW-1:0]    comp,
    output logic [vln_pkg::CompW-1:0]           mag,
    output logic                                neg,
    output logic [vln_pkg::SqW-1:0]             square
);

    logic [vln_pkg::CompW-1:0] mag_a_reg;
    logic                      neg_a_reg;
    logic [vln_pkg::CompW-1:0] mag_b_reg;
    logic                      neg_b_reg;
    logic [vln_pkg::SqW-1:0]   sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= comp[vln_pkg::CompW-1];
            mag_a_reg <= comp[vln_pkg::CompW-1] ? (~comp + 1'b1) : comp;
            neg_b_reg <= neg_a_reg;
            mag_b_reg <= mag_a_reg;
            sq_reg    <= vln_pkg::SqW'(mag_a_reg) * vln_pkg::SqW'(mag_a_reg);
        end
    end

    assign mag    = mag_b_reg;
    assign neg    = neg_b_reg;
    assign square = sq_reg;

endmodule

// ===== hdl/vln_sqrt_pipe.sv =====
// vln_sqrt_pipe: integer square root of a 64-bit sum, one result bit per stage.
// Depends on vln_pkg.
`timescale 1ns / 1ps

module vln_sqrt_pipe
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [vln_pkg::SqW-1:0]      sum,
    output logic [vln_pkg::CompW-1:0]    root
);

    logic [vln_pkg::SqW-1:0] n_reg    [vln_pkg::SqrtSteps];
    logic [vln_pkg::SqW-1:0] root_reg [vln_pkg::SqrtSteps];

    for (genvar k = 0; k < vln_pkg::SqrtSteps; k++)
    begin : g_step
        localparam logic [vln_pkg::SqW-1:0] Bit = 64'd1 << (62 - 2 * k);
        logic [vln_pkg::SqW-1:0] n_in;
        logic [vln_pkg::SqW-1:0] r_in;
        logic [vln_pkg::SqW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_in = sum;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = root_reg[k-1];
        end

        assign trial = r_in + Bit;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_in >= trial)
                begin
                    n_reg[k]    <= n_in - trial;
                    root_reg[k] <= (r_in >> 1) + Bit;
                end
                else
                begin
                    n_reg[k]    <= n_in;
                    root_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign root = root_reg[vln_pkg::SqrtSteps-1][vln_pkg::CompW-1:0];

endmodule

// ===== hdl/vln_div_lane.sv =====
// vln_div_lane: restoring divider, (mag << 30) / len, one quotient bit per stage.
// Depends on vln_pkg.
`timescale 1ns / 1ps

module vln_div_lane
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [vln_pkg::CompW-1:0]     mag,
    input  logic [vln_pkg::CompW-1:0]     len,
    output logic [vln_pkg::QuotW-1:0]     quot
);

    logic [vln_pkg::CompW-1:0] r_reg   [vln_pkg::DivSteps];
    logic [vln_pkg::QuotW-1:0] q_reg   [vln_pkg::DivSteps];
    logic [vln_pkg::CompW-1:0] len_reg [vln_pkg::DivSteps];

    for (genvar j = 0; j < vln_pkg::DivSteps; j++)
    begin : g_step
        logic [vln_pkg::CompW:0]   r_in;
        logic [vln_pkg::CompW:0]   r_sub;
        logic [vln_pkg::QuotW-1:0] q_in;
        logic [vln_pkg::CompW-1:0] d_in;
        logic                      ge;

        if (j == 0)
        begin : g_first
            assign r_in = {1'b0, mag};
            assign q_in = '0;
            assign d_in = len;
        end
        else
        begin : g_rest
            assign r_in = {r_reg[j-1], 1'b0};
            assign q_in = q_reg[j-1];
            assign d_in = len_reg[j-1];
        end

        assign ge    = r_in >= {1'b0, d_in};
        assign r_sub = r_in - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= ge ? r_sub[vln_pkg::CompW-1:0] : r_in[vln_pkg::CompW-1:0];
                q_reg[j]   <= {q_in[vln_pkg::QuotW-2:0], ge};
                len_reg[j] <= d_in;
            end
        end
    end

    assign quot = q_reg[vln_pkg::DivSteps-1];

endmodule

// ===== hdl/vector_length_and_normalize.sv =====
// vector_length_and_normalize: top level; square lanes, sum, sqrt pipe, divider lanes, merge.
// Depends on vln_pkg, vln_square_lane, vln_sqrt_pipe, vln_div_lane.
//
//  channel | valid     | stall     | word
//  in      | in_valid  | in_stall  | vec_x, vec_y, vec_z
//  out     | out_valid | out_stall | vec_length, unit_x, unit_y, unit_z, zero_length
//
// One word per cycle while in_stall is low; stages are 2 square, 1 sum, 32 sqrt, 31 divide,
// 1 output, with one root bit and one quotient bit per stage.
// rst_n clears valid bits and the output/skid flags; data regs are not reset.
// A result arriving while the output word is stalled lands in a skid register; in_stall rises once it is full.
`timescale 1ns / 1ps

module vector_length_and_normalize
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [vln_pkg::CompW-1:0]   vec_x,
    input  logic signed [vln_pkg::CompW-1:0]   vec_y,
    input  logic signed [vln_pkg::CompW-1:0]   vec_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vln_pkg::CompW-1:0]          vec_length,
    output logic signed [vln_pkg::CompW-1:0]   unit_x,
    output logic signed [vln_pkg::CompW-1:0]   unit_y,
    output logic signed [vln_pkg::CompW-1:0]   unit_z,
    output logic                               zero_length
);

    localparam int Depth = 3 + vln_pkg::SqrtSteps + vln_pkg::DivSteps;

    logic en;
    logic [Depth-1:0] v_reg;

    logic signed [vln_pkg::CompW-1:0] comp [vln_pkg::Lanes];
    logic [vln_pkg::CompW-1:0] sq_mag [vln_pkg::Lanes];
    logic                      sq_neg [vln_pkg::Lanes];
    logic [vln_pkg::SqW-1:0]   sq     [vln_pkg::Lanes];

    logic [vln_pkg::SqW-1:0]   sum_reg;
    logic [vln_pkg::CompW-1:0] mag_reg [vln_pkg::SqrtSteps+1][vln_pkg::Lanes];
    logic [vln_pkg::Lanes-1:0] neg_reg [vln_pkg::SqrtSteps+1];
    logic [vln_pkg::CompW-1:0] root;

    logic [vln_pkg::CompW-1:0] len_reg  [vln_pkg::DivSteps];
    logic [vln_pkg::Lanes-1:0] dneg_reg [vln_pkg::DivSteps];
    logic [vln_pkg::QuotW-1:0] quot [vln_pkg::Lanes];
    logic signed [vln_pkg::CompW-1:0] unit [vln_pkg::Lanes];

    vln_pkg::res_t res;
    vln_pkg::res_t out_reg;
    vln_pkg::res_t skid_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_full_reg;
    logic skid_full_next;

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    assign comp[0] = vec_x;
    assign comp[1] = vec_y;
    assign comp[2] = vec_z;

    for (genvar l = 0; l < vln_pkg::Lanes; l++)
    begin : g_lane
        vln_square_lane u_sq
        (
            .clk    (clk),
            .en     (en),
            .comp   (comp[l]),
            .mag    (sq_mag[l]),
            .neg    (sq_neg[l]),
            .square (sq[l])
        );

        vln_div_lane u_div
        (
            .clk  (clk),
            .en   (en),
            .mag  (mag_reg[vln_pkg::SqrtSteps][l]),
            .len  (root),
            .quot (quot[l])
        );

        always_comb
        begin
            if (len_reg[vln_pkg::DivSteps-1] == '0)
                unit[l] = '0;
            else if (dneg_reg[vln_pkg::DivSteps-1][l])
                unit[l] = -$signed({1'b0, quot[l]});
            else
                unit[l] = $signed({1'b0, quot[l]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[Depth-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sq[0] + sq[1] + sq[2];
            for (int l = 0; l < vln_pkg::Lanes; l++)
            begin
                mag_reg[0][l] <= sq_mag[l];
                neg_reg[0][l] <= sq_neg[l];
            end
            for (int s = 1; s <= vln_pkg::SqrtSteps; s++)
            begin
                mag_reg[s] <= mag_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            len_reg[0]  <= root;
            dneg_reg[0] <= neg_reg[vln_pkg::SqrtSteps];
            for (int s = 1; s < vln_pkg::DivSteps; s++)
            begin
                len_reg[s]  <= len_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
            end
        end
    end

    vln_sqrt_pipe u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .sum  (sum_reg),
        .root (root)
    );

    always_comb
    begin
        res.vec_length  = len_reg[vln_pkg::DivSteps-1];
        res.unit_x      = unit[0];
        res.unit_y      = unit[1];
        res.unit_z      = unit[2];
        res.zero_length = (len_reg[vln_pkg::DivSteps-1] == '0);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (!out_stall)
                skid_full_next = 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
            out_valid_next = v_reg[Depth-1];
        else if (v_reg[Depth-1])
            skid_full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (!out_stall)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || !out_stall)
            out_reg <= res;
        else
            skid_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign vec_length  = out_reg.vec_length;
    assign unit_x      = out_reg.unit_x;
    assign unit_y      = out_reg.unit_y;
    assign unit_z      = out_reg.unit_z;
    assign zero_length = out_reg.zero_length;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid full without output word");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !out_stall |=> out_valid_reg && !skid_full_reg)
        else $error("skid did not drain");

    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
        else $error("nonzero unit on zero length");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zero_length == (vec_length == '0))
        else $error("zero flag mismatch");
`endif

endmodule
